// ===== src/barometric_calibration_compensator_core_defines.svh =====
// Assertion macros shared by the barometric compensator RTL
`ifndef BAROMETRIC_CALIBRATION_COMPENSATOR_CORE_DEFINES_SVH
`define BAROMETRIC_CALIBRATION_COMPENSATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bcc_pkg.sv =====
// Shared types and constants of the barometric compensator
package bcc_pkg;

    localparam int unsigned ADC_W      = 20;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PRESSURE_MODE   = 3'd0,
        CFG_TEMP_CAL        = 3'd1,
        CFG_PRESS_CAL_LOW   = 3'd2,
        CFG_PRESS_CAL_HIGH  = 3'd3,
        CFG_PRESS_CAL_LAST  = 3'd4
    } cfg_addr_t;

    // Calibration set as seen by the datapath
    typedef struct packed {
        logic        pressure_mode;
        logic [47:0] temp_cal;
        logic [63:0] press_cal_low;
        logic [63:0] press_cal_high;
        logic [15:0] press_cal_last;
    } bcc_cal_t;

    // Item passed from the front end to the compensation pipeline
    typedef struct packed {
        logic [31:0]      d1;
        logic [31:0]      d2;
        logic [ADC_W-1:0] adc_pressure;
    } bcc_item_t;

    // Formula constants
    localparam logic [31:0] TEMP_ROUND   = 32'd128;
    localparam logic [34:0] P64_OFFSET   = 35'd128000;
    localparam logic [31:0] P32_OFFSET   = 32'd64000;
    localparam logic [31:0] P32_BIAS     = 32'd32768;
    localparam logic [63:0] P64_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [20:0] PRESS_FULL   = 21'd1048576;
    localparam logic [31:0] PRESS_SCALE  = 32'd3125;

    // Pipeline layout of the back end
    localparam int unsigned DIV_W       = 64;
    localparam int unsigned PRE_STAGES  = 13;
    localparam int unsigned POST_STAGES = 6;
    localparam int unsigned N_STAGES    = PRE_STAGES + DIV_W + POST_STAGES + 1;
    localparam int unsigned TEMP_STAGE  = 3;
    localparam int unsigned TEMP_LINE   = N_STAGES - TEMP_STAGE - 1;

endpackage

// ===== src/bcc_front.sv =====
// Input stage: accepts readings and forms the temperature differences
module bcc_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bcc_pkg::ADC_W-1:0]   s_adc_temperature,
    input  logic [bcc_pkg::ADC_W-1:0]   s_adc_pressure,
    input  logic [15:0]                 t1,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bcc_pkg::bcc_item_t          out_item
);

    logic               f_valid_reg, f_valid_next;
    bcc_pkg::bcc_item_t f_item_reg, f_item_next;
    logic               take;

    assign s_ready   = !f_valid_reg || out_ready;
    assign take      = s_valid && s_ready;
    assign out_valid = f_valid_reg;
    assign out_item  = f_item_reg;

    // Temperature differences against T1
    always_comb begin
        f_item_next.d1 = ({12'b0, s_adc_temperature} >> 3) - ({16'b0, t1} << 1);
        f_item_next.d2 = ({12'b0, s_adc_temperature} >> 4) - {16'b0, t1};
        f_item_next.adc_pressure = s_adc_pressure;
        if (take) begin
            f_valid_next = 1'b1;
        end else if (out_ready) begin
            f_valid_next = 1'b0;
        end else begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

// ===== src/bcc_queue.sv =====
// Short item queue between the front end and the compensation pipeline
module bcc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bcc_pkg::bcc_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output bcc_pkg::bcc_item_t out_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bcc_pkg::bcc_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    // Pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== src/bcc_back.sv =====
// Compensation pipeline: temperature, both pressure paths and a shared divider
module bcc_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bcc_pkg::bcc_cal_t          cal,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bcc_pkg::bcc_item_t         in_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [31:0]                m_temperature,
    output logic [31:0]                m_pressure,
    output logic                       m_pressure_invalid
);

    localparam int unsigned N  = bcc_pkg::N_STAGES;
    localparam int unsigned DW = bcc_pkg::DIV_W;

    logic adv;
    logic [N-1:0] vld_reg;

    // Coefficients
    logic [15:0]        p1;
    logic [31:0]        t2_32, t3_32, p1_32;
    logic [31:0]        p2_32, p3_32, p4_32, p5_32, p6_32, p7_32, p8_32, p9_32;
    logic signed [15:0] p2s, p3s, p5s, p6s, p8s, p9s;
    logic [63:0]        p4_64;

    assign p1    = cal.press_cal_low[15:0];
    assign t2_32 = {{16{cal.temp_cal[31]}}, cal.temp_cal[31:16]};
    assign t3_32 = {{16{cal.temp_cal[47]}}, cal.temp_cal[47:32]};
    assign p1_32 = {16'b0, p1};
    assign p2s   = $signed(cal.press_cal_low[31:16]);
    assign p3s   = $signed(cal.press_cal_low[47:32]);
    assign p5s   = $signed(cal.press_cal_high[15:0]);
    assign p6s   = $signed(cal.press_cal_high[31:16]);
    assign p8s   = $signed(cal.press_cal_high[63:48]);
    assign p9s   = $signed(cal.press_cal_last);
    assign p2_32 = {{16{p2s[15]}}, p2s};
    assign p3_32 = {{16{p3s[15]}}, p3s};
    assign p4_32 = {{16{cal.press_cal_low[63]}}, cal.press_cal_low[63:48]};
    assign p4_64 = {{48{cal.press_cal_low[63]}}, cal.press_cal_low[63:48]};
    assign p5_32 = {{16{p5s[15]}}, p5s};
    assign p6_32 = {{16{p6s[15]}}, p6s};
    assign p7_32 = {{16{cal.press_cal_high[47]}}, cal.press_cal_high[47:32]};
    assign p8_32 = {{16{p8s[15]}}, p8s};
    assign p9_32 = {{16{p9s[15]}}, p9s};

    // Whole pipeline moves while the output register is free or being taken
    assign adv      = !vld_reg[N-1] || m_ready;
    assign in_ready = adv;
    assign m_valid  = vld_reg[N-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    // ---------------- temperature and front of both pressure paths ----------------
    logic [31:0] m1_reg, m1_next, dd_reg, dd_next;
    logic [19:0] ap1_reg, ap2_reg, ap3_reg, ap4_reg, ap5_reg, ap6_reg, ap7_reg, ap8_reg;
    logic [31:0] v1t_reg, v1t_next, m2t_reg, m2t_next;
    logic [31:0] tf_reg, tf_next;
    logic [31:0] temp_next, t5;
    logic signed [34:0] va64_reg, va64_next;
    logic [31:0] va32_reg, va32_next;
    logic [63:0] sq64_reg, sq64_next, m5_64_reg, m5_64_next, m2_64_reg, m2_64_next;
    logic signed [31:0] q32;
    logic [31:0] sq32_reg, sq32_next, m5_32_reg, m5_32_next, m2_32_reg, m2_32_next;
    logic [63:0] sqp6_lo_reg, sqp6_lo_next, sqp3_lo_reg, sqp3_lo_next;
    logic [31:0] sqp6_hi_reg, sqp6_hi_next, sqp3_hi_reg, sqp3_hi_next;
    logic [31:0] a6_reg, a6_next, a3_reg, a3_next, sq32_sh11, sq32_sh13;
    logic [63:0] m5_64b_reg, m2_64b_reg;
    logic [31:0] m5_32b_reg, m2_32b_reg;
    logic [63:0] sqp6_reg, sqp6_next, sqp3_reg, sqp3_next, m5_64c_reg, m2_64c_reg;
    logic [31:0] v2_32_reg, v2_32_next, v1b_reg, v1b_next, v2_sum, v1_sum;
    logic [63:0] v2_64_reg, v2_64_next, v1a_reg, v1a_next;
    logic [31:0] x32_reg, x32_next, num32_reg, num32_next;
    logic [63:0] x64_reg, x64_next, num64_reg, num64_next;
    logic [20:0] pn;
    logic [31:0] d32m_reg, d32m_next, n32_reg, n32_next;
    logic [47:0] xp_lo_reg, xp_lo_next;
    logic [43:0] np_lo_reg, np_lo_next;
    logic [31:0] xp_hi_reg, xp_hi_next, np_hi_reg, np_hi_next;
    logic [31:0] d32_reg, d32_next, n32b_reg;
    logic [63:0] w_reg, w_next, n64_reg, n64_next;
    logic [31:0] d32b_reg, n32c_reg;
    logic [63:0] d64_reg, d64_next, n64b_reg;
    logic [31:0] d32c_reg, n32d_reg;

    always_comb begin
        // s1
        m1_next   = in_item.d1 * t2_32;
        dd_next   = in_item.d2 * in_item.d2;
        // s2
        v1t_next  = $signed(m1_reg) >>> 11;
        m2t_next  = 32'($signed(dd_reg) >>> 12) * t3_32;
        // s3
        tf_next   = v1t_reg + 32'($signed(m2t_reg) >>> 14);
        // s4
        t5        = (tf_reg * 32'd5) + bcc_pkg::TEMP_ROUND;
        temp_next = $signed(t5) >>> 8;
        va64_next = 35'($signed(tf_reg)) - $signed(bcc_pkg::P64_OFFSET);
        va32_next = 32'($signed(tf_reg) >>> 1) - bcc_pkg::P32_OFFSET;
        // s5
        sq64_next  = 64'(va64_reg * va64_reg);
        m5_64_next = 64'(va64_reg * p5s);
        m2_64_next = 64'(va64_reg * p2s);
        q32        = $signed(va32_reg) >>> 2;
        sq32_next  = q32 * q32;
        m5_32_next = va32_reg * p5_32;
        m2_32_next = p2_32 * va32_reg;
        // s6
        sqp6_lo_next = 64'($signed({1'b0, sq64_reg[31:0]}) * p6s);
        sqp6_hi_next = sq64_reg[63:32] * p6_32;
        sqp3_lo_next = 64'($signed({1'b0, sq64_reg[31:0]}) * p3s);
        sqp3_hi_next = sq64_reg[63:32] * p3_32;
        sq32_sh11    = $signed(sq32_reg) >>> 11;
        sq32_sh13    = $signed(sq32_reg) >>> 13;
        a6_next      = sq32_sh11 * p6_32;
        a3_next      = p3_32 * sq32_sh13;
        // s7
        sqp6_next  = sqp6_lo_reg + {sqp6_hi_reg, 32'b0};
        sqp3_next  = sqp3_lo_reg + {sqp3_hi_reg, 32'b0};
        v2_sum     = a6_reg + (m5_32b_reg << 1);
        v2_32_next = 32'($signed(v2_sum) >>> 2) + (p4_32 << 16);
        v1_sum     = 32'($signed(a3_reg) >>> 3) + 32'($signed(m2_32b_reg) >>> 1);
        v1b_next   = $signed(v1_sum) >>> 18;
        // s8
        v2_64_next = sqp6_reg + (m5_64c_reg << 17) + (p4_64 << 35);
        v1a_next   = 64'($signed(sqp3_reg) >>> 8) + (m2_64c_reg << 12);
        x32_next   = bcc_pkg::P32_BIAS + v1b_reg;
        num32_next = ({11'b0, bcc_pkg::PRESS_FULL} - {12'b0, ap7_reg})
                   - 32'($signed(v2_32_reg) >>> 12);
        // s9
        pn         = bcc_pkg::PRESS_FULL - {1'b0, ap8_reg};
        x64_next   = v1a_reg + bcc_pkg::P64_BIAS;
        num64_next = ({43'b0, pn} << 31) - v2_64_reg;
        d32m_next  = x32_reg * p1_32;
        n32_next   = num32_reg * bcc_pkg::PRESS_SCALE;
        // s10
        xp_lo_next = x64_reg[31:0] * p1;
        xp_hi_next = x64_reg[63:32] * p1_32;
        np_lo_next = num64_reg[31:0] * bcc_pkg::PRESS_SCALE[11:0];
        np_hi_next = num64_reg[63:32] * bcc_pkg::PRESS_SCALE;
        d32_next   = $signed(d32m_reg) >>> 15;
        // s11
        w_next     = {16'b0, xp_lo_reg} + {xp_hi_reg, 32'b0};
        n64_next   = {20'b0, np_lo_reg} + {np_hi_reg, 32'b0};
        // s12
        d64_next   = $signed(w_reg) >>> 33;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_reg      <= m1_next;
            dd_reg      <= dd_next;
            ap1_reg     <= in_item.adc_pressure;
            v1t_reg     <= v1t_next;
            m2t_reg     <= m2t_next;
            ap2_reg     <= ap1_reg;
            tf_reg      <= tf_next;
            ap3_reg     <= ap2_reg;
            va64_reg    <= va64_next;
            va32_reg    <= va32_next;
            ap4_reg     <= ap3_reg;
            sq64_reg    <= sq64_next;
            m5_64_reg   <= m5_64_next;
            m2_64_reg   <= m2_64_next;
            sq32_reg    <= sq32_next;
            m5_32_reg   <= m5_32_next;
            m2_32_reg   <= m2_32_next;
            ap5_reg     <= ap4_reg;
            sqp6_lo_reg <= sqp6_lo_next;
            sqp6_hi_reg <= sqp6_hi_next;
            sqp3_lo_reg <= sqp3_lo_next;
            sqp3_hi_reg <= sqp3_hi_next;
            a6_reg      <= a6_next;
            a3_reg      <= a3_next;
            m5_64b_reg  <= m5_64_reg;
            m2_64b_reg  <= m2_64_reg;
            m5_32b_reg  <= m5_32_reg;
            m2_32b_reg  <= m2_32_reg;
            ap6_reg     <= ap5_reg;
            sqp6_reg    <= sqp6_next;
            sqp3_reg    <= sqp3_next;
            m5_64c_reg  <= m5_64b_reg;
            m2_64c_reg  <= m2_64b_reg;
            v2_32_reg   <= v2_32_next;
            v1b_reg     <= v1b_next;
            ap7_reg     <= ap6_reg;
            v2_64_reg   <= v2_64_next;
            v1a_reg     <= v1a_next;
            x32_reg     <= x32_next;
            num32_reg   <= num32_next;
            ap8_reg     <= ap7_reg;
            x64_reg     <= x64_next;
            num64_reg   <= num64_next;
            d32m_reg    <= d32m_next;
            n32_reg     <= n32_next;
            xp_lo_reg   <= xp_lo_next;
            xp_hi_reg   <= xp_hi_next;
            np_lo_reg   <= np_lo_next;
            np_hi_reg   <= np_hi_next;
            d32_reg     <= d32_next;
            n32b_reg    <= n32_reg;
            w_reg       <= w_next;
            n64_reg     <= n64_next;
            d32b_reg    <= d32_reg;
            n32c_reg    <= n32b_reg;
            d64_reg     <= d64_next;
            n64b_reg    <= n64_reg;
            d32c_reg    <= d32b_reg;
            n32d_reg    <= n32c_reg;
        end
    end

    // Temperature travels alongside the pressure work
    logic [31:0] temp_line_reg [bcc_pkg::TEMP_LINE];

    always_ff @(posedge aclk) begin
        if (adv) begin
            temp_line_reg[0] <= temp_next;
            for (int i = 1; i < bcc_pkg::TEMP_LINE; i++) begin
                temp_line_reg[i] <= temp_line_reg[i-1];
            end
        end
    end

    // ---------------- divider set-up: magnitudes, signs, zero check ----------------
    logic [63:0] dvd_reg, dvd_next, dvs_reg, dvs_next;
    logic        neg_reg, neg_next, dbl_reg, dbl_next, zero_reg, zero_next;

    always_comb begin
        if (cal.pressure_mode) begin
            dvd_next  = {32'b0, n32d_reg[31] ? n32d_reg : (n32d_reg << 1)};
            dvs_next  = {32'b0, d32c_reg};
            neg_next  = 1'b0;
            dbl_next  = n32d_reg[31];
            zero_next = (d32c_reg == '0);
        end else begin
            dvd_next  = n64b_reg[63] ? (64'd0 - n64b_reg) : n64b_reg;
            dvs_next  = d64_reg[63] ? (64'd0 - d64_reg) : d64_reg;
            neg_next  = n64b_reg[63] ^ d64_reg[63];
            dbl_next  = 1'b0;
            zero_next = (d64_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dvd_reg  <= dvd_next;
            dvs_reg  <= dvs_next;
            neg_reg  <= neg_next;
            dbl_reg  <= dbl_next;
            zero_reg <= zero_next;
        end
    end

    // ---------------- pipelined restoring divider, one quotient bit a stage ----------------
    logic [63:0] dv_rem_reg [DW];
    logic [63:0] dv_quo_reg [DW];
    logic [63:0] dv_dvs_reg [DW];
    logic        dv_neg_reg [DW];
    logic        dv_dbl_reg [DW];
    logic        dv_zero_reg [DW];

    for (genvar k = 0; k < DW; k++) begin : g_div
        logic [63:0] rem_in, quo_in, dvs_in;
        logic        neg_in, dbl_in, zero_in;
        logic [64:0] trial, diff;
        logic [63:0] rem_next, quo_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign quo_in  = dvd_reg;
            assign dvs_in  = dvs_reg;
            assign neg_in  = neg_reg;
            assign dbl_in  = dbl_reg;
            assign zero_in = zero_reg;
        end else begin : g_rest
            assign rem_in  = dv_rem_reg[k-1];
            assign quo_in  = dv_quo_reg[k-1];
            assign dvs_in  = dv_dvs_reg[k-1];
            assign neg_in  = dv_neg_reg[k-1];
            assign dbl_in  = dv_dbl_reg[k-1];
            assign zero_in = dv_zero_reg[k-1];
        end

        always_comb begin
            trial = {rem_in, quo_in[63]};
            diff  = trial - {1'b0, dvs_in};
            if (!diff[64]) begin
                rem_next = diff[63:0];
                quo_next = {quo_in[62:0], 1'b1};
            end else begin
                rem_next = trial[63:0];
                quo_next = {quo_in[62:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[k]  <= rem_next;
                dv_quo_reg[k]  <= quo_next;
                dv_dvs_reg[k]  <= dvs_in;
                dv_neg_reg[k]  <= neg_in;
                dv_dbl_reg[k]  <= dbl_in;
                dv_zero_reg[k] <= zero_in;
            end
        end
    end

    // ---------------- quotient fix-up and pressure tail ----------------
    logic [63:0] q;
    logic [63:0] p64_reg, p64_next, p64a_reg, p64b_reg, p64c_reg, p64d_reg;
    logic [31:0] p32_reg, p32_next, p32a_reg, p32b_reg, p32c_reg;
    logic [bcc_pkg::POST_STAGES-1:0] zline_reg;
    logic [63:0] a_next, a_reg, ab_reg;
    logic [63:0] p9a_lo_reg, p9a_lo_next, p8p_lo_reg, p8p_lo_next;
    logic [31:0] p9a_hi_reg, p9a_hi_next, p8p_hi_reg, p8p_hi_next;
    logic [31:0] pa32_reg, pa32_next, pb32_reg, pb32_next, pb32b_reg;
    logic [63:0] p9a_reg, p9a_next, p8p_reg, p8p_next;
    logic [31:0] c32_reg, c32_next;
    logic [63:0] pr_ll_reg, pr_ll_next, v2p_reg, v2p_next, v2pb_reg;
    logic [31:0] pr_x_reg, pr_x_next, s32_reg, s32_next;
    logic [63:0] t64_reg, t64_next;
    logic [31:0] r32_reg, r32_next, r32b_reg;
    logic [63:0] sum_reg, sum_next, sum_sh;
    logic [31:0] press64;
    logic [31:0] out_press_next;

    always_comb begin
        q        = dv_quo_reg[DW-1];
        p64_next = dv_neg_reg[DW-1] ? (64'd0 - q) : q;
        p32_next = dv_dbl_reg[DW-1] ? {q[30:0], 1'b0} : q[31:0];
        // pA1
        a_next      = $signed(p64_reg) >>> 13;
        p9a_lo_next = 64'($signed({1'b0, a_next[31:0]}) * p9s);
        p9a_hi_next = a_next[63:32] * p9_32;
        p8p_lo_next = 64'($signed({1'b0, p64_reg[31:0]}) * p8s);
        p8p_hi_next = p64_reg[63:32] * p8_32;
        pa32_next   = (p32_reg >> 3) * (p32_reg >> 3);
        pb32_next   = (p32_reg >> 2) * p8_32;
        // pA2
        p9a_next = p9a_lo_reg + {p9a_hi_reg, 32'b0};
        p8p_next = p8p_lo_reg + {p8p_hi_reg, 32'b0};
        c32_next = p9_32 * (pa32_reg >> 13);
        // pA3
        pr_ll_next = 64'(p9a_reg[31:0] * ab_reg[31:0]);
        pr_x_next  = (p9a_reg[31:0] * ab_reg[63:32]) + (p9a_reg[63:32] * ab_reg[31:0]);
        v2p_next   = $signed(p8p_reg) >>> 19;
        s32_next   = 32'($signed(c32_reg) >>> 12) + 32'($signed(pb32b_reg) >>> 13) + p7_32;
        // pA4
        t64_next = pr_ll_reg + {pr_x_reg, 32'b0};
        r32_next = p32c_reg + 32'($signed(s32_reg) >>> 4);
        // pA5
        sum_next = p64d_reg + 64'($signed(t64_reg) >>> 25) + v2pb_reg;
        // output
        sum_sh   = $signed(sum_reg) >>> 8;
        press64  = sum_sh[31:0] + (p7_32 << 4);
        if (zline_reg[bcc_pkg::POST_STAGES-1]) begin
            out_press_next = '0;
        end else if (cal.pressure_mode) begin
            out_press_next = r32b_reg;
        end else begin
            out_press_next = press64;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p64_reg     <= p64_next;
            p32_reg     <= p32_next;
            zline_reg   <= {zline_reg[bcc_pkg::POST_STAGES-2:0], dv_zero_reg[DW-1]};
            a_reg       <= a_next;
            p64a_reg    <= p64_reg;
            p9a_lo_reg  <= p9a_lo_next;
            p9a_hi_reg  <= p9a_hi_next;
            p8p_lo_reg  <= p8p_lo_next;
            p8p_hi_reg  <= p8p_hi_next;
            pa32_reg    <= pa32_next;
            pb32_reg    <= pb32_next;
            p32a_reg    <= p32_reg;
            p9a_reg     <= p9a_next;
            p8p_reg     <= p8p_next;
            ab_reg      <= a_reg;
            p64b_reg    <= p64a_reg;
            c32_reg     <= c32_next;
            pb32b_reg   <= pb32_reg;
            p32b_reg    <= p32a_reg;
            pr_ll_reg   <= pr_ll_next;
            pr_x_reg    <= pr_x_next;
            v2p_reg     <= v2p_next;
            p64c_reg    <= p64b_reg;
            s32_reg     <= s32_next;
            p32c_reg    <= p32b_reg;
            t64_reg     <= t64_next;
            v2pb_reg    <= v2p_reg;
            p64d_reg    <= p64c_reg;
            r32_reg     <= r32_next;
            sum_reg     <= sum_next;
            r32b_reg    <= r32_reg;
            // output register
            m_temperature      <= temp_line_reg[bcc_pkg::TEMP_LINE-1];
            m_pressure         <= out_press_next;
            m_pressure_invalid <= zline_reg[bcc_pkg::POST_STAGES-1];
        end
    end

endmodule

// ===== src/barometric_calibration_compensator_core.sv =====
// Throughput: one item per cycle while the output is not stalled; the 64-stage divider takes a new item each cycle.
// Output stalls freeze the whole compensation pipeline; the queue absorbs the front end.
// Reset (aresetn low, synchronous) empties all stages and clears the calibration to zero.
// Top level: configuration registers, front end, queue and compensation pipeline
`include "barometric_calibration_compensator_core_defines.svh"

module barometric_calibration_compensator_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bcc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bcc_pkg::ADC_W-1:0]          s_adc_temperature,
    input  logic [bcc_pkg::ADC_W-1:0]          s_adc_pressure,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bcc_pkg::DATA_W-1:0]  m_temperature,
    output logic [bcc_pkg::DATA_W-1:0]         m_pressure,
    output logic                               m_pressure_invalid
);

    bcc_pkg::bcc_cal_t  cal_reg;
    bcc_pkg::bcc_item_t front_item, q_item;
    logic               front_valid, q_ready, q_valid, back_ready;
    logic [31:0]        temp_u;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bcc_pkg::CFG_PRESSURE_MODE:  cal_reg.pressure_mode  <= cfg_wdata[0];
                bcc_pkg::CFG_TEMP_CAL:       cal_reg.temp_cal       <= cfg_wdata[47:0];
                bcc_pkg::CFG_PRESS_CAL_LOW:  cal_reg.press_cal_low  <= cfg_wdata;
                bcc_pkg::CFG_PRESS_CAL_HIGH: cal_reg.press_cal_high <= cfg_wdata;
                bcc_pkg::CFG_PRESS_CAL_LAST: cal_reg.press_cal_last <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    bcc_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_adc_temperature (s_adc_temperature),
        .s_adc_pressure    (s_adc_pressure),
        .t1                (cal_reg.temp_cal[15:0]),
        .out_valid         (front_valid),
        .out_ready         (q_ready),
        .out_item          (front_item)
    );

    bcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (q_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (back_ready),
        .out_item  (q_item)
    );

    bcc_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cal                (cal_reg),
        .in_valid           (q_valid),
        .in_ready           (back_ready),
        .in_item            (q_item),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_temperature      (temp_u),
        .m_pressure         (m_pressure),
        .m_pressure_invalid (m_pressure_invalid)
    );

    assign m_temperature = $signed(temp_u);

    // A zero divisor must force pressure to zero
    `BCC_ASSERT_NOW(a_invalid_zero, aclk, aresetn, m_valid && m_pressure_invalid, m_pressure == '0, "invalid pressure not zeroed")
    // The pipeline only stalls behind a held result
    `BCC_ASSERT_NOW(a_stall_cause, aclk, aresetn, !back_ready, m_valid && !m_ready, "pipeline stalled without a held result")
    // A front-end item blocked by a full queue stays put
    `BCC_ASSERT_NEXT(a_front_hold, aclk, aresetn, front_valid && !q_ready, front_valid, "front item dropped while queue full")

endmodule
